// ===== src/ssmb_pkg.sv =====
// Shared types and constants for the scaled sprite mask blitter.
// No dependencies; every other file of the block imports this package.
package ssmb_pkg;

  // fixed field widths
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned LOAD_IDX_W = 12;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned OFS_W      = 9;
  localparam int unsigned FRAME_W    = 17;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned ALPHA_LSB  = 24;

  // dividend width of the divider pipes: origin plus offset needs one more bit
  localparam int unsigned SUM_W = OFS_W + 1;

  // store address field, wide enough for the largest source store
  localparam int unsigned STORE_ADDR_W = 16;

  // configuration register widths
  localparam int unsigned ORIGIN_X_W = 9;
  localparam int unsigned ORIGIN_Y_W = 8;
  localparam int unsigned SRC_DIM_W  = 7;
  localparam int unsigned SCALE_W    = 4;

  // APB port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW = 1'b1;

  // register indexes (word address)
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_SRC_W     = 3'd2,
    REG_SRC_H     = 3'd3,
    REG_SCALE     = 3'd4
  } ssmb_reg_e;

  // reset values
  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RST = 7'd64;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 4'd2;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [ORIGIN_X_W-1:0] origin_x;
    logic [ORIGIN_Y_W-1:0] origin_y;
    logic [SRC_DIM_W-1:0]  src_w;
    logic [SRC_DIM_W-1:0]  src_h;
    logic [SCALE_W-1:0]    scale;
  } ssmb_cfg_t;

  // classified request handed from front to back through the queue
  typedef struct packed {
    logic                    is_load;
    logic                    hit;          // load in store range / draw inside sprite
    logic                    force_black;  // draw index beyond the store
    logic [STORE_ADDR_W-1:0] store_addr;
    logic [ALPHA_W-1:0]      alpha;
    logic [FRAME_W-1:0]      frame_address;
  } ssmb_req_t;

endpackage

// ===== src/ssmb_if.sv =====
// Valid/ready channel interfaces of the blitter: request in, result out.
// Depends on ssmb_pkg for the field widths.
interface ssmb_in_if
  import ssmb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [LOAD_IDX_W-1:0] load_index;
  logic [PIXEL_W-1:0]    load_pixel;
  logic [OFS_W-1:0]      offset_x;
  logic [OFS_W-1:0]      offset_y;

  modport source (output valid, func, load_index, load_pixel, offset_x, offset_y,
                  input ready);
  modport sink   (input valid, func, load_index, load_pixel, offset_x, offset_y,
                  output ready);
endinterface

interface ssmb_out_if
  import ssmb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_address;
  logic               write_black;

  modport source (output valid, frame_address, write_black, input ready);
  modport sink   (input valid, frame_address, write_black, output ready);
endinterface

// ===== src/ssmb_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, SUM_W stages.
// Depends on ssmb_pkg. The divisor must hold steady while items are in flight.
module ssmb_div_pipe
  import ssmb_pkg::*;
#(
  parameter int unsigned DVS_W = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [SUM_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o
);

  logic [DVS_W-1:0] rem_d [SUM_W];
  logic [DVS_W-1:0] rem_q [SUM_W];
  logic [SUM_W-1:0] quo_d [SUM_W];
  logic [SUM_W-1:0] quo_q [SUM_W];
  logic [SUM_W-1:0] dvd_d [SUM_W];
  logic [SUM_W-1:0] dvd_q [SUM_W];

  // one trial subtraction per stage
  for (genvar k = 0; k < SUM_W; k++) begin : g_stage
    logic [DVS_W-1:0] rem_prev;
    logic [SUM_W-1:0] dvd_prev;
    logic [SUM_W-1:0] quo_prev;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign dvd_prev = dividend_i;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_q[k-1];
      assign dvd_prev = dvd_q[k-1];
      assign quo_prev = quo_q[k-1];
    end

    assign trial    = {rem_prev, dvd_prev[SUM_W-1]};
    assign diff     = trial - {1'b0, divisor_i};
    assign take     = trial >= {1'b0, divisor_i};
    assign rem_d[k] = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    assign dvd_d[k] = {dvd_prev[SUM_W-2:0], 1'b0};
    assign quo_d[k] = {quo_prev[SUM_W-2:0], take};
  end

  // stage registers move together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q[SUM_W-1];
  assign remainder_o = rem_q[SUM_W-1];

endmodule

// ===== src/ssmb_front.sv =====
// Front end: accepts requests, classifies them, runs the divider pipes for source
// coordinates and a reciprocal multiply for screen wrap. Depends on ssmb_pkg, ssmb_if, ssmb_div_pipe.
module ssmb_front
  import ssmb_pkg::*;
#(
  parameter int unsigned WIN_WIDTH   = 400,
  parameter int unsigned WIN_HEIGHT  = 250,
  parameter int unsigned MAX_SRC_DIM = 64,
  parameter int unsigned MAX_SCALE   = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ssmb_cfg_t    cfg_i,
  ssmb_in_if.sink      in_i,
  input  logic         space_i,
  output logic         push_o,
  output ssmb_req_t    push_data_o
);

  localparam int unsigned NSTG   = SUM_W;
  localparam int unsigned DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int unsigned DIM_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int unsigned SCL_W  = $clog2(MAX_SCALE + 1);
  localparam int unsigned WW_W   = $clog2(WIN_WIDTH + 1);
  localparam int unsigned WH_W   = $clog2(WIN_HEIGHT + 1);
  localparam int unsigned PROD_W = DIM_W + SCL_W;

  // reciprocal constants: floor(n * RCP >> SH) == n / WIN for every n below 2**SUM_W
  localparam int unsigned WX_SH  = SUM_W + $clog2(WIN_WIDTH);
  localparam int unsigned WY_SH  = SUM_W + $clog2(WIN_HEIGHT);
  localparam int unsigned WX_RCP = ((1 << WX_SH) + WIN_WIDTH - 1) / WIN_WIDTH;
  localparam int unsigned WY_RCP = ((1 << WY_SH) + WIN_HEIGHT - 1) / WIN_HEIGHT;
  localparam int unsigned PX_W   = WX_SH + SUM_W;
  localparam int unsigned PY_W   = WY_SH + SUM_W;

  typedef struct packed {
    logic                  is_load;
    logic                  hit;
    logic [LOAD_IDX_W-1:0] ld_idx;
    logic [ALPHA_W-1:0]    alpha;
  } meta_t;

  logic              en;
  logic [NSTG-1:0]   vld_q;
  meta_t             meta_d;
  meta_t             meta_q [NSTG];

  logic [31:0]       w_full, h_full, s_full;
  logic [DIM_W-1:0]  w, h;
  logic [SCL_W-1:0]  s;
  logic [PROD_W-1:0] w_scaled, h_scaled;
  logic              draw_ok;

  logic [SUM_W-1:0]  wsum_x, wsum_y;
  logic [PX_W-1:0]   wprd_x;
  logic [PY_W-1:0]   wprd_y;
  logic [SUM_W-1:0]  wsum_x_q, wsum_y_q;
  logic [SUM_W-1:0]  wquo_x_q, wquo_y_q;
  logic [31:0]       wrem_x, wrem_y;
  logic [WW_W-1:0]   mx_q [NSTG-1];
  logic [WH_W-1:0]   my_q [NSTG-1];

  logic [SUM_W-1:0]  sx, sy;
  logic [WW_W-1:0]   mx;
  logic [WH_W-1:0]   my;
  logic [31:0]       idx, addr;

  // pipeline moves whenever its last stage is empty or drains into the queue
  assign en         = !vld_q[NSTG-1] || space_i;
  assign in_i.ready = en;
  assign push_o     = vld_q[NSTG-1] && space_i;

  // saturate geometry to the supported maximums
  always_comb begin
    w_full = (32'(cfg_i.src_w) > MAX_SRC_DIM) ? 32'(MAX_SRC_DIM) : 32'(cfg_i.src_w);
    h_full = (32'(cfg_i.src_h) > MAX_SRC_DIM) ? 32'(MAX_SRC_DIM) : 32'(cfg_i.src_h);
    s_full = (32'(cfg_i.scale) > MAX_SCALE)   ? 32'(MAX_SCALE)   : 32'(cfg_i.scale);
    w      = w_full[DIM_W-1:0];
    h      = h_full[DIM_W-1:0];
    s      = s_full[SCL_W-1:0];
  end

  // classify at acceptance: scaled-size range check, alpha extraction
  always_comb begin
    w_scaled       = PROD_W'(w) * PROD_W'(s);
    h_scaled       = PROD_W'(h) * PROD_W'(s);
    draw_ok        = (s != '0) && (32'(in_i.offset_x) < 32'(w_scaled))
                     && (32'(in_i.offset_y) < 32'(h_scaled));
    meta_d.is_load = (in_i.func == FUNC_LOAD);
    meta_d.ld_idx  = in_i.load_index;
    meta_d.alpha   = in_i.load_pixel[ALPHA_LSB +: ALPHA_W];
    meta_d.hit     = meta_d.is_load ? (32'(in_i.load_index) < DEPTH) : draw_ok;
  end

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // request metadata rides alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_d;
      for (int k = 1; k < NSTG; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // source column and row
  ssmb_div_pipe #(.DVS_W(SCL_W)) u_div_x (
    .clk_i       (clk_i),
    .en_i        (en),
    .dividend_i  (SUM_W'(in_i.offset_x)),
    .divisor_i   (s),
    .quotient_o  (sx),
    .remainder_o ()
  );

  ssmb_div_pipe #(.DVS_W(SCL_W)) u_div_y (
    .clk_i       (clk_i),
    .en_i        (en),
    .dividend_i  (SUM_W'(in_i.offset_y)),
    .divisor_i   (s),
    .quotient_o  (sy),
    .remainder_o ()
  );

  // screen wrap: quotient by reciprocal multiply, remainder one stage later
  always_comb begin
    wsum_x = SUM_W'(cfg_i.origin_x) + SUM_W'(in_i.offset_x);
    wsum_y = SUM_W'(cfg_i.origin_y) + SUM_W'(in_i.offset_y);
    wprd_x = PX_W'(wsum_x) * PX_W'(WX_RCP);
    wprd_y = PY_W'(wsum_y) * PY_W'(WY_RCP);
    wrem_x = 32'(wsum_x_q) - 32'(wquo_x_q) * WIN_WIDTH;
    wrem_y = 32'(wsum_y_q) - 32'(wquo_y_q) * WIN_HEIGHT;
  end

  // wrap stages, delayed to line up with the divider outputs
  always_ff @(posedge clk_i) begin
    if (en) begin
      wsum_x_q <= wsum_x;
      wsum_y_q <= wsum_y;
      wquo_x_q <= wprd_x[WX_SH +: SUM_W];
      wquo_y_q <= wprd_y[WY_SH +: SUM_W];
      mx_q[0]  <= wrem_x[WW_W-1:0];
      my_q[0]  <= wrem_y[WH_W-1:0];
      for (int k = 1; k < NSTG - 1; k++) begin
        mx_q[k] <= mx_q[k-1];
        my_q[k] <= my_q[k-1];
      end
    end
  end

  assign mx = mx_q[NSTG-2];
  assign my = my_q[NSTG-2];

  // store index and frame address, registered in the queue
  always_comb begin
    idx  = 32'(sy) * 32'(w) + 32'(sx);
    addr = 32'(my) * WIN_WIDTH + 32'(mx);
    push_data_o.is_load       = meta_q[NSTG-1].is_load;
    push_data_o.hit           = meta_q[NSTG-1].hit;
    push_data_o.force_black   = !(idx < DEPTH);
    push_data_o.store_addr    = meta_q[NSTG-1].is_load ?
                                STORE_ADDR_W'(meta_q[NSTG-1].ld_idx) : idx[STORE_ADDR_W-1:0];
    push_data_o.alpha         = meta_q[NSTG-1].alpha;
    push_data_o.frame_address = addr[FRAME_W-1:0];
  end

endmodule

// ===== src/ssmb_queue.sv =====
// Four-entry request queue between front and back ends.
// Depends on ssmb_pkg for the request type.
module ssmb_queue
  import ssmb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ssmb_req_t push_data_i,
  output logic      space_o,
  input  logic      pop_i,
  output logic      not_empty_o,
  output ssmb_req_t pop_data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  ssmb_req_t        entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign space_o     = cnt_q < (PTR_W+1)'(DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign pop_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/ssmb_back.sv =====
// Back end: alpha store write/read and the result register.
// Depends on ssmb_pkg and ssmb_if.
module ssmb_back
  import ssmb_pkg::*;
#(
  parameter int unsigned MAX_SRC_DIM = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      not_empty_i,
  input  ssmb_req_t pop_data_i,
  output logic      pop_o,
  ssmb_out_if.source out_o
);

  localparam int unsigned DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ALPHA_W-1:0] alpha_mem [DEPTH];
  logic [ALPHA_W-1:0] rd_q;
  logic [AW-1:0]      mem_addr;

  logic               s1_vld_q, out_vld_q;
  ssmb_req_t          s1_req_q;
  logic [FRAME_W-1:0] frame_q;
  logic               black_q;
  logic               s1_adv, out_adv, is_draw;

  assign out_adv  = !out_vld_q || out_o.ready;
  assign s1_adv   = !s1_vld_q || out_adv;
  assign pop_o    = not_empty_i && s1_adv;
  assign mem_addr = pop_data_i.store_addr[AW-1:0];
  assign is_draw  = !s1_req_q.is_load && s1_req_q.hit;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv)  s1_vld_q  <= pop_o;
      if (out_adv) out_vld_q <= s1_vld_q;
    end
  end

  // alpha store: loads write, draws read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (pop_data_i.is_load && pop_data_i.hit) begin
        alpha_mem[mem_addr] <= pop_data_i.alpha;
      end
      rd_q     <= alpha_mem[mem_addr];
      s1_req_q <= pop_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_vld_q) begin
      frame_q <= is_draw ? s1_req_q.frame_address : '0;
      black_q <= is_draw && (s1_req_q.force_black || (rd_q == '0));
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.frame_address = frame_q;
  assign out_o.write_black   = black_q;

endmodule

// ===== src/scaled_sprite_mask_blit_top.sv =====
// Top level of the scaled sprite mask blitter: APB registers, front end,
// request queue and back end. Depends on ssmb_pkg, ssmb_if, ssmb_front, ssmb_queue, ssmb_back.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------------
//   in_i     | in        | valid/ready         | func, load_index, load_pixel, offset_x/y
//   out_o    | out       | valid/ready         | frame_address, write_black
//   APB      | in        | psel/penable/pready | paddr, pwdata, prdata
//
// One request per cycle sustained while out_o.ready stays high; the accepting edge loads the
// first of ten front stages (one quotient bit per stage), then the queue write, the store read
// and the result register follow, and the result register drives out_o.valid.
// Reset clears control state and loads register defaults; the alpha store is not cleared.
// A stalled result holds in the output register while the queue keeps taking requests;
// the front end stalls only when its last stage is full and the four-entry queue is full.
module scaled_sprite_mask_blit_top
  import ssmb_pkg::*;
#(
  parameter int unsigned WIN_WIDTH   = 400,
  parameter int unsigned WIN_HEIGHT  = 250,
  parameter int unsigned MAX_SRC_DIM = 64,
  parameter int unsigned MAX_SCALE   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ssmb_in_if.sink               in_i,
  ssmb_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ssmb_cfg_t cfg_q;
  ssmb_reg_e reg_sel;
  logic      wr_en;
  logic      push, space, pop, not_empty;
  ssmb_req_t push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = ssmb_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.src_w    <= SRC_DIM_RST;
      cfg_q.src_h    <= SRC_DIM_RST;
      cfg_q.scale    <= SCALE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ORIGIN_X: cfg_q.origin_x <= pwdata[ORIGIN_X_W-1:0];
        REG_ORIGIN_Y: cfg_q.origin_y <= pwdata[ORIGIN_Y_W-1:0];
        REG_SRC_W:    cfg_q.src_w    <= pwdata[SRC_DIM_W-1:0];
        REG_SRC_H:    cfg_q.src_h    <= pwdata[SRC_DIM_W-1:0];
        REG_SCALE:    cfg_q.scale    <= pwdata[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_ORIGIN_X: prdata = APB_DATA_W'(cfg_q.origin_x);
      REG_ORIGIN_Y: prdata = APB_DATA_W'(cfg_q.origin_y);
      REG_SRC_W:    prdata = APB_DATA_W'(cfg_q.src_w);
      REG_SRC_H:    prdata = APB_DATA_W'(cfg_q.src_h);
      REG_SCALE:    prdata = APB_DATA_W'(cfg_q.scale);
      default:      prdata = '0;
    endcase
  end

  ssmb_front #(
    .WIN_WIDTH   (WIN_WIDTH),
    .WIN_HEIGHT  (WIN_HEIGHT),
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_SCALE   (MAX_SCALE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .space_i     (space),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ssmb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (pop_data)
  );

  ssmb_back #(
    .MAX_SRC_DIM (MAX_SRC_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (not_empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== dv/scaled_sprite_mask_blit_top_tb.sv =====
// Self-checking testbench for scaled_sprite_mask_blit_top: loads and draws go in, and each
// frame write coming out is compared against an in-order prediction of the scaled blit.
// Depends on ssmb_pkg, ssmb_if and the RTL of the block under src/.
module scaled_sprite_mask_blit_top_tb
  import ssmb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_W       = 400;
  localparam int unsigned WIN_H       = 250;
  localparam int unsigned SRC_MAX     = 64;
  localparam int unsigned SCALE_MAX   = 8;
  localparam int unsigned STORE_DEPTH = SRC_MAX * SRC_MAX;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [PIXEL_W-1:0]    load_pixel;
    logic [OFS_W-1:0]      offset_x;
    logic [OFS_W-1:0]      offset_y;
  } blit_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_address;
    logic               write_black;
  } frame_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ssmb_in_if  in_if ();
  ssmb_out_if out_if ();

  scaled_sprite_mask_blit_top #(
    .WIN_WIDTH   (WIN_W),
    .WIN_HEIGHT  (WIN_H),
    .MAX_SRC_DIM (SRC_MAX),
    .MAX_SCALE   (SCALE_MAX)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state: register copy, alpha mirror and pending frame writes
  ssmb_cfg_t          cfg_shadow;
  logic [ALPHA_W-1:0] alpha_mirror [STORE_DEPTH];
  bit                 alpha_known  [STORE_DEPTH];
  frame_write_t       pending_writes [$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count    = 0;
  int unsigned        sink_hold      = 0;
  bit                 steady         = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // effective sprite geometry after saturation
  function automatic bit sprite_index(input logic [OFS_W-1:0] ox, input logic [OFS_W-1:0] oy,
                                      output int unsigned idx);
    int unsigned w, h, s;
    w = (cfg_shadow.src_w > SRC_MAX) ? SRC_MAX : cfg_shadow.src_w;
    h = (cfg_shadow.src_h > SRC_MAX) ? SRC_MAX : cfg_shadow.src_h;
    s = (cfg_shadow.scale > SCALE_MAX) ? SCALE_MAX : cfg_shadow.scale;
    idx = 0;
    if (s == 0 || ox >= w * s || oy >= h * s) return 1'b0;
    idx = (oy / s) * w + (ox / s);
    return 1'b1;
  endfunction

  // scaled size along x, zero when width or scale is zero
  function automatic int unsigned span_x();
    int unsigned w, s;
    w = (cfg_shadow.src_w > SRC_MAX) ? SRC_MAX : cfg_shadow.src_w;
    s = (cfg_shadow.scale > SCALE_MAX) ? SCALE_MAX : cfg_shadow.scale;
    return w * s;
  endfunction

  function automatic int unsigned span_y();
    int unsigned h, s;
    h = (cfg_shadow.src_h > SRC_MAX) ? SRC_MAX : cfg_shadow.src_h;
    s = (cfg_shadow.scale > SCALE_MAX) ? SCALE_MAX : cfg_shadow.scale;
    return h * s;
  endfunction

  // apply one accepted request to the mirror and work out its frame write
  function automatic frame_write_t predict_blit(input blit_req_t rq);
    frame_write_t fw;
    int unsigned  idx, col, row;
    fw = '0;
    if (rq.func == FUNC_LOAD) begin
      if (rq.load_index < STORE_DEPTH) begin
        alpha_mirror[rq.load_index] = rq.load_pixel[ALPHA_LSB +: ALPHA_W];
        alpha_known[rq.load_index]  = 1'b1;
      end
    end else if (sprite_index(rq.offset_x, rq.offset_y, idx)) begin
      col = (int'(cfg_shadow.origin_x) + int'(rq.offset_x)) % WIN_W;
      row = (int'(cfg_shadow.origin_y) + int'(rq.offset_y)) % WIN_H;
      fw.frame_address = FRAME_W'(row * WIN_W + col);
      fw.write_black   = (alpha_mirror[idx] == '0);
    end
    return fw;
  endfunction

  // pixel word with zero alpha about half the time
  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [PIXEL_W-1:0] px;
    px = $urandom();
    if ($urandom_range(0, 1) == 0) px[ALPHA_LSB +: ALPHA_W] = '0;
    return px;
  endfunction

  // one request through the input channel; valid stays up across back-to-back requests
  task automatic send_request(input blit_req_t rq);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= rq.func;
    in_if.load_index <= rq.load_index;
    in_if.load_pixel <= rq.load_pixel;
    in_if.offset_x   <= rq.offset_x;
    in_if.offset_y   <= rq.offset_y;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_writes.push_back(predict_blit(rq));
  endtask

  task automatic load_alpha(input int unsigned idx, input logic [PIXEL_W-1:0] px);
    blit_req_t rq;
    rq.func       = FUNC_LOAD;
    rq.load_index = LOAD_IDX_W'(idx);
    rq.load_pixel = px;
    rq.offset_x   = OFS_W'($urandom());
    rq.offset_y   = OFS_W'($urandom());
    send_request(rq);
  endtask

  // draw request; a never-written source entry gets loaded first
  task automatic draw_at(input int unsigned ox, input int unsigned oy);
    blit_req_t   rq;
    int unsigned idx;
    if (sprite_index(OFS_W'(ox), OFS_W'(oy), idx) && !alpha_known[idx])
      load_alpha(idx, random_pixel());
    rq.func       = FUNC_DRAW;
    rq.load_index = LOAD_IDX_W'($urandom());
    rq.load_pixel = $urandom();
    rq.offset_x   = OFS_W'(ox);
    rq.offset_y   = OFS_W'(oy);
    send_request(rq);
  endtask

  // drop valid and wait until every predicted write has come out
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // APB write: setup cycle, then access cycle; register updates at the access edge
  task automatic write_reg(input ssmb_reg_e r, input logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ORIGIN_X: cfg_shadow.origin_x = v[ORIGIN_X_W-1:0];
      REG_ORIGIN_Y: cfg_shadow.origin_y = v[ORIGIN_Y_W-1:0];
      REG_SRC_W:    cfg_shadow.src_w    = v[SRC_DIM_W-1:0];
      REG_SRC_H:    cfg_shadow.src_h    = v[SRC_DIM_W-1:0];
      REG_SCALE:    cfg_shadow.scale    = v[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned ox, input int unsigned oy,
                              input int unsigned w, input int unsigned h,
                              input int unsigned s);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SRC_W, w);
    write_reg(REG_SRC_H, h);
    write_reg(REG_SCALE, s);
  endtask

  // reset geometry 64x64 at scale 2: corners, scaled-size edges and far offsets
  task automatic test_reset_values();
    load_alpha(0, 32'h00FF_FFFF);
    load_alpha(STORE_DEPTH - 1, 32'hFFFF_FFFF);
    draw_at(0, 0);
    draw_at(127, 127);
    draw_at(128, 5);
    draw_at(5, 128);
    draw_at(511, 511);
  endtask

  // origin at the last window pixel, largest legal size: any nonzero offset wraps on its axis
  task automatic test_window_wrap();
    set_geometry(WIN_W - 1, WIN_H - 1, SRC_MAX, SRC_MAX, SCALE_MAX);
    load_alpha(1, 32'h0100_0000);
    draw_at(0, 0);
    draw_at(8, 0);
    draw_at(511, 511);
  endtask

  // width, height and scale above their maximum, origin beyond the window
  task automatic test_saturation();
    set_geometry(511, 255, 127, 65, 15);
    draw_at(511, 511);
    draw_at(0, 0);
    set_geometry(WIN_W, WIN_H, 65, 127, 9);
    draw_at(300, 511);
  endtask

  // zero width, height or scale: nothing is ever drawn
  task automatic test_zero_size();
    set_geometry(10, 20, 0, 16, 2);
    draw_at(0, 0);
    set_geometry(10, 20, 16, 0, 2);
    draw_at(3, 0);
    set_geometry(10, 20, 16, 16, 0);
    draw_at(0, 0);
    draw_at(511, 511);
  endtask

  // random mix: loads, draws inside the sprite and draws anywhere
  task automatic run_mix(input int unsigned n, input bit calm);
    int unsigned pick, sx, sy;
    steady = calm;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      sx   = span_x();
      sy   = span_y();
      if (pick < 25)
        load_alpha($urandom_range(0, STORE_DEPTH - 1), random_pixel());
      else if (pick < 85 && sx > 0 && sy > 0)
        draw_at($urandom_range(0, sx - 1), $urandom_range(0, sy - 1));
      else
        draw_at($urandom_range(0, 511), $urandom_range(0, 511));
    end
    steady = 1'b0;
  endtask

  // draws of unseen source pixels add a load each, so the mix counts stay modest
  task automatic test_random_traffic();
    set_geometry($urandom_range(0, WIN_W - 1), $urandom_range(0, WIN_H - 1),
                 $urandom_range(1, SRC_MAX), $urandom_range(1, SRC_MAX),
                 $urandom_range(1, SCALE_MAX));
    run_mix(80, 1'b0);
    run_mix(50, 1'b1);
    set_geometry(WIN_W - 1, WIN_H - 1, SRC_MAX, SRC_MAX, SCALE_MAX);
    run_mix(60, 1'b0);
    set_geometry(0, 0, 1, 1, 1);
    run_mix(40, 1'b0);
    // any field value, legal or not
    set_geometry($urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 15));
    run_mix(70, 1'b0);
    set_geometry($urandom_range(0, WIN_W - 1), $urandom_range(0, WIN_H - 1),
                 $urandom_range(1, SRC_MAX), $urandom_range(1, SRC_MAX),
                 $urandom_range(1, SCALE_MAX));
    run_mix(50, 1'b0);
  endtask

  // result side: random back-pressure, off while steady
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) sink_hold = idle_len();
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_writes
    frame_write_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr=%0d black=%0b",
                 $time, out_if.frame_address, out_if.write_black);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_if.frame_address !== want.frame_address) begin
          $display("%0t: frame_address mismatch, expected %0d, actual %0d",
                   $time, want.frame_address, out_if.frame_address);
          mismatch_count++;
        end
        if (out_if.write_black !== want.write_black) begin
          $display("%0t: write_black mismatch, expected %0b, actual %0b",
                   $time, want.write_black, out_if.write_black);
          mismatch_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scaled_sprite_mask_blit_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_LOAD;
    in_if.load_index = '0;
    in_if.load_pixel = '0;
    in_if.offset_x   = '0;
    in_if.offset_y   = '0;
    out_if.ready     = 1'b0;
    cfg_shadow       = '{origin_x: '0, origin_y: '0, src_w: SRC_DIM_RST,
                         src_h: SRC_DIM_RST, scale: SCALE_RST};
    foreach (alpha_known[i]) alpha_known[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_window_wrap();
    test_saturation();
    test_zero_size();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("scaled_sprite_mask_blit_top verification clean");
    end else begin
      $display("scaled_sprite_mask_blit_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ssmb_pkg.sv
src/ssmb_if.sv
src/ssmb_div_pipe.sv
src/ssmb_front.sv
src/ssmb_queue.sv
src/ssmb_back.sv
src/scaled_sprite_mask_blit_top.sv
dv/scaled_sprite_mask_blit_top_tb.sv
